@@ design/stack_machine_word_executor_core_assert.svh @@
// Assertion macros for the stack word executor.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STACK_MACHINE_WORD_EXECUTOR_CORE_ASSERT_SVH
`define STACK_MACHINE_WORD_EXECUTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SMWE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SMWE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SMWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SMWE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMWE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SMWE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/smwe_pkg.sv @@
// Shared types, constants and decode helpers for the stack word executor.
// No dependencies; imported by smwe_alu, the top level and the testbench.
package smwe_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int WORD_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DEPTH_W     = 7;
	localparam int STATUS_W    = 3;
	localparam int ACT_W       = 4;
	localparam int ITER_W      = $clog2(WORD_W);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 4'd0,
		ACT_ADD     = 4'd1,
		ACT_SUB     = 4'd2,
		ACT_MUL     = 4'd3,
		ACT_DIV     = 4'd4,
		ACT_MOD     = 4'd5,
		ACT_PEEK    = 4'd6,
		ACT_POP     = 4'd7,
		ACT_SWAP    = 4'd8,
		ACT_DUP     = 4'd9,
		ACT_DROP    = 4'd10,
		ACT_NIP     = 4'd11,
		ACT_OVER    = 4'd12,
		ACT_TOR     = 4'd13,
		ACT_RFROM   = 4'd14,
		ACT_UNKNOWN = 4'd15
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_REM
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [WORD_W-1:0] literal;
	} cmd_t;

	typedef struct packed {
		logic                     print_valid;
		logic signed [WORD_W-1:0] print_value;
		logic [STATUS_W-1:0]      status;
		logic [DEPTH_W-1:0]       depth;
	} rsp_t;

	// entries a word needs on the stack
	function automatic logic [1:0] need_of(input action_t act);
		logic [1:0] n;
		n = 2'd0;
		unique case (act) inside
			ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_SWAP, ACT_NIP, ACT_OVER: n = 2'd2;
			ACT_PEEK, ACT_POP, ACT_DUP, ACT_DROP, ACT_TOR: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	// words that add one entry
	function automatic logic grow_of(input action_t act);
		logic g;
		g = 1'b0;
		unique case (act) inside
			ACT_PUSH, ACT_DUP, ACT_OVER, ACT_RFROM: g = 1'b1;
			default: g = 1'b0;
		endcase
		return g;
	endfunction

	function automatic logic is_arith(input action_t act);
		logic r;
		r = 1'b0;
		unique case (act) inside
			ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ design/smwe_ram.sv @@
// Generic one-write, one-read synchronous RAM with registered read data.
// No package dependencies; holds the data stack entries.
module smwe_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/smwe_alu.sv @@
// Iterative arithmetic unit: one shared adder serves add, sub, shift-add
// multiply and restoring signed divide/remainder. Depends on smwe_pkg.
module smwe_alu (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smwe_pkg::alu_req_t       req,
	input  logic [smwe_pkg::WORD_W-1:0] top_val,
	input  logic [smwe_pkg::WORD_W-1:0] nxt_val,
	output logic                     done,
	output logic [smwe_pkg::WORD_W-1:0] result
);

	import smwe_pkg::*;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ONE,
		A_MUL,
		A_ABSA,
		A_ABSB,
		A_DIV,
		A_FIX
	} phase_t;

	phase_t              phase_q;
	alu_op_t             op_q;
	logic [ITER_W-1:0]   cnt_q;
	logic [WORD_W-1:0]   x_q;
	logic [WORD_W-1:0]   y_q;
	logic [WORD_W-1:0]   z_q;
	logic                sa_q;
	logic                sb_q;
	logic                done_q;
	logic [WORD_W-1:0]   res_q;

	logic [WORD_W+1:0]   add_x;
	logic [WORD_W-1:0]   add_y;
	logic                add_sub;
	logic [WORD_W+1:0]   sum;
	logic                neg_res;

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (phase_q)
			A_ONE: begin
				add_x   = {2'b00, x_q};
				add_y   = y_q;
				add_sub = (op_q == ALU_SUB);
			end
			A_MUL: begin
				add_x = {2'b00, x_q};
				add_y = y_q;
			end
			A_ABSA: begin
				add_y   = y_q;
				add_sub = 1'b1;
			end
			A_ABSB: begin
				add_y   = z_q;
				add_sub = 1'b1;
			end
			A_DIV: begin
				add_x   = {1'b0, x_q, z_q[WORD_W-1]};
				add_y   = y_q;
				add_sub = 1'b1;
			end
			A_FIX: begin
				add_y   = (op_q == ALU_DIV) ? z_q : x_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
		sum = add_x + ({2'b00, add_y} ^ {(WORD_W+2){add_sub}}) + (WORD_W+2)'(add_sub);
		neg_res = (op_q == ALU_DIV) ? (sa_q ^ sb_q) : sb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						cnt_q <= '0;
						sa_q  <= top_val[WORD_W-1];
						sb_q  <= nxt_val[WORD_W-1];
						case (req.op)
							ALU_ADD, ALU_SUB: begin
								x_q     <= nxt_val;
								y_q     <= top_val;
								phase_q <= A_ONE;
							end
							ALU_MUL: begin
								x_q     <= '0;
								y_q     <= nxt_val;
								z_q     <= top_val;
								phase_q <= A_MUL;
							end
							default: begin
								x_q     <= '0;
								y_q     <= top_val;
								z_q     <= nxt_val;
								phase_q <= A_ABSA;
							end
						endcase
					end
				end
				A_ONE: begin
					res_q   <= sum[WORD_W-1:0];
					done_q  <= 1'b1;
					phase_q <= A_IDLE;
				end
				A_MUL: begin
					if (z_q[0]) begin
						x_q <= sum[WORD_W-1:0];
					end
					y_q   <= y_q << 1;
					z_q   <= z_q >> 1;
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(WORD_W - 1)) begin
						res_q   <= z_q[0] ? sum[WORD_W-1:0] : x_q;
						done_q  <= 1'b1;
						phase_q <= A_IDLE;
					end
				end
				A_ABSA: begin
					if (sa_q) begin
						y_q <= sum[WORD_W-1:0];
					end
					phase_q <= A_ABSB;
				end
				A_ABSB: begin
					if (sb_q) begin
						z_q <= sum[WORD_W-1:0];
					end
					phase_q <= A_DIV;
				end
				A_DIV: begin
					if (!sum[WORD_W+1]) begin
						x_q <= sum[WORD_W-1:0];
						z_q <= {z_q[WORD_W-2:0], 1'b1};
					end else begin
						x_q <= {x_q[WORD_W-2:0], z_q[WORD_W-1]};
						z_q <= {z_q[WORD_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + ITER_W'(1);
					if (cnt_q == ITER_W'(WORD_W - 1)) begin
						phase_q <= A_FIX;
					end
				end
				A_FIX: begin
					if (neg_res) begin
						res_q <= sum[WORD_W-1:0];
					end else begin
						res_q <= (op_q == ALU_DIV) ? z_q : x_q;
					end
					done_q  <= 1'b1;
					phase_q <= A_IDLE;
				end
				default: begin
					phase_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ design/stack_machine_word_executor_core.sv @@
// Words with unknown, underflow or overflow status go straight to the response; push and rfrom
// write first; other words read their operands, and arithmetic words then run the ALU, where
// multiply and divide take one shared-adder step per bit. Divide by zero skips the ALU.
// cmd_ready returns the cycle after the response is registered, so one word is in flight at
// a time; a held response that waits for rsp_ready delays it. Reset clears the stack
// count, the return register and the response; stack memory contents stay undefined.
// Top level: sequencer, stack memory, return register. Uses smwe_pkg, smwe_ram, smwe_alu.
`include "stack_machine_word_executor_core_assert.svh"
module stack_machine_word_executor_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  smwe_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output smwe_pkg::rsp_t rsp
);

	import smwe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_GETA,
		S_GETB,
		S_ALU,
		S_WR,
		S_WR2,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] ret_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	status_t           status_q;
	logic              pvalid_q;

	action_t           act_q;
	logic [WORD_W-1:0] lit_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] r_q;

	action_t           in_act;
	logic [1:0]        need_in;
	status_t           chk_st;
	logic [1:0]        need_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	alu_req_t          alu_req;
	logic              alu_done;
	logic [WORD_W-1:0] alu_res;

	logic [ADDR_W-1:0] addr_top;
	logic [ADDR_W-1:0] addr_nxt;
	logic [ADDR_W-1:0] addr_new;
	logic              take;
	logic              div_zero;

	assign in_act   = action_t'(cmd.action);
	assign need_in  = need_of(in_act);
	assign need_q   = need_of(act_q);
	assign take     = cmd_valid && cmd_ready;
	assign addr_top = ADDR_W'(count_q - CNT_W'(1));
	assign addr_nxt = ADDR_W'(count_q - CNT_W'(2));
	assign addr_new = ADDR_W'(count_q);
	assign div_zero = (act_q == ACT_DIV || act_q == ACT_MOD) && (a_q == '0);

	always_comb begin
		if (in_act == ACT_UNKNOWN) begin
			chk_st = ST_UNKNOWN;
		end else if (count_q < CNT_W'(need_in)) begin
			chk_st = ST_UNDERFLOW;
		end else if (grow_of(in_act) && count_q >= CNT_W'(STACK_DEPTH)) begin
			chk_st = ST_OVERFLOW;
		end else begin
			chk_st = ST_OK;
		end
	end

	always_comb begin
		ram_raddr = (state_q == S_RDB) ? addr_nxt : addr_top;
		ram_we    = 1'b0;
		ram_waddr = addr_new;
		ram_wdata = a_q;
		if (state_q == S_WR) begin
			unique case (act_q) inside
				ACT_PUSH: begin
					ram_we    = 1'b1;
					ram_wdata = lit_q;
				end
				ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
					ram_we    = 1'b1;
					ram_waddr = addr_nxt;
					ram_wdata = r_q;
				end
				ACT_SWAP: begin
					ram_we    = 1'b1;
					ram_waddr = addr_top;
					ram_wdata = b_q;
				end
				ACT_DUP: begin
					ram_we = 1'b1;
				end
				ACT_NIP: begin
					ram_we    = 1'b1;
					ram_waddr = addr_nxt;
				end
				ACT_OVER: begin
					ram_we    = 1'b1;
					ram_wdata = b_q;
				end
				ACT_RFROM: begin
					ram_we    = 1'b1;
					ram_wdata = ret_q;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (state_q == S_WR2) begin
			ram_we    = 1'b1;
			ram_waddr = addr_nxt;
		end
	end

	always_comb begin
		alu_req.start = (state_q == S_GETB) && is_arith(act_q) && !div_zero;
		unique case (act_q) inside
			ACT_SUB: alu_req.op = ALU_SUB;
			ACT_MUL: alu_req.op = ALU_MUL;
			ACT_DIV: alu_req.op = ALU_DIV;
			ACT_MOD: alu_req.op = ALU_REM;
			default: alu_req.op = ALU_ADD;
		endcase
	end

	smwe_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	smwe_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (alu_req),
		.top_val (a_q),
		.nxt_val (ram_rdata),
		.done    (alu_done),
		.result  (alu_res)
	);

	// operand and payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= in_act;
			lit_q <= cmd.literal;
		end
		if (state_q == S_GETA || state_q == S_RDB) begin
			a_q <= ram_rdata;
		end
		if (state_q == S_GETB) begin
			b_q <= ram_rdata;
		end
		if (state_q == S_ALU && alu_done) begin
			r_q <= alu_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ret_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			status_q    <= ST_OK;
			pvalid_q    <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						status_q <= chk_st;
						pvalid_q <= 1'b0;
						if (chk_st != ST_OK) begin
							state_q <= S_RESP;
						end else if (need_in == 2'd0) begin
							state_q <= S_WR;
						end else begin
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: begin
					state_q <= (need_q == 2'd2) ? S_RDB : S_GETA;
				end
				S_RDB: begin
					state_q <= S_GETB;
				end
				S_GETA: begin
					state_q <= S_WR;
				end
				S_GETB: begin
					if (div_zero) begin
						status_q <= ST_DIVZERO;
						state_q  <= S_RESP;
					end else if (is_arith(act_q)) begin
						state_q <= S_ALU;
					end else begin
						state_q <= S_WR;
					end
				end
				S_ALU: begin
					if (alu_done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					unique case (act_q) inside
						ACT_PUSH, ACT_DUP, ACT_OVER, ACT_RFROM: begin
							count_q <= count_q + CNT_W'(1);
						end
						ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_DROP, ACT_NIP: begin
							count_q <= count_q - CNT_W'(1);
						end
						ACT_POP: begin
							count_q  <= count_q - CNT_W'(1);
							pvalid_q <= 1'b1;
						end
						ACT_TOR: begin
							count_q <= count_q - CNT_W'(1);
							ret_q   <= a_q;
						end
						ACT_PEEK: begin
							pvalid_q <= 1'b1;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
					state_q <= (act_q == ACT_SWAP) ? S_WR2 : S_RESP;
				end
				S_WR2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.print_valid <= pvalid_q;
						rsp_q.print_value <= pvalid_q ? a_q : '0;
						rsp_q.status      <= status_q;
						rsp_q.depth       <= DEPTH_W'(count_q);
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SMWE_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(STACK_DEPTH), "stack count above depth")
	`SMWE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, take, !cmd_ready, "ready right after accept")
	`SMWE_ASSERT_IMPL(a_alu_start_state, clk, arst_n, alu_req.start, state_q == S_GETB, "alu started outside operand fetch")
	`SMWE_ASSERT_IMPL(a_print_ok, clk, arst_n, rsp_valid_q && rsp_q.print_valid, rsp_q.status == ST_OK, "print with error status")

endmodule

@@ tb/sv/stack_machine_word_executor_core_tb.sv @@
// Self-checking testbench for stack_machine_word_executor_core: directed words, then random
// word streams with stack fills and drains, checked against an in-bench stack predictor.
// Depends on smwe_pkg and the RTL of the block only.
module stack_machine_word_executor_core_tb;
	import smwe_pkg::*;

	class word_scoreboard;
		logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
		int unsigned sp;
		logic [WORD_W-1:0] ret_word;
		rsp_t awaited[$];
		int faults;
		int checked;

		function new();
			sp = 0;
			ret_word = '0;
			faults = 0;
			checked = 0;
		endfunction

		function logic [WORD_W-1:0] entry(int unsigned k);
			return stack_mem[sp - 1 - k];
		endfunction

		function void note_word(cmd_t c);
			action_t act;
			logic [WORD_W-1:0] a, b, r;
			longint qa, qb;
			int unsigned need;
			bit grow;
			rsp_t e;
			act = action_t'(c.action);
			e = '0;
			e.status = ST_OK;
			need = 0;
			grow = 1'b0;
			case (act)
				ACT_PUSH, ACT_RFROM: grow = 1'b1;
				ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_SWAP, ACT_NIP: need = 2;
				ACT_OVER: begin
					need = 2;
					grow = 1'b1;
				end
				ACT_DUP: begin
					need = 1;
					grow = 1'b1;
				end
				ACT_PEEK, ACT_POP, ACT_DROP, ACT_TOR: need = 1;
				default: e.status = ST_UNKNOWN;
			endcase
			if (e.status == ST_OK) begin
				if (sp < need)
					e.status = ST_UNDERFLOW;
				else if (grow && sp >= STACK_DEPTH)
					e.status = ST_OVERFLOW;
				else if ((act == ACT_DIV || act == ACT_MOD) && entry(0) == '0)
					e.status = ST_DIVZERO;
			end
			if (e.status == ST_OK) begin
				case (act)
					ACT_PUSH: begin
						stack_mem[sp] = c.literal;
						sp++;
					end
					ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
						a = entry(0);
						b = entry(1);
						qa = $signed(a);
						qb = $signed(b);
						sp--;
						case (act)
							ACT_ADD: r = a + b;
							ACT_SUB: r = b - a;
							ACT_MUL: r = a * b;
							ACT_DIV: r = WORD_W'(qb / qa);
							default: r = WORD_W'(qb % qa);
						endcase
						stack_mem[sp - 1] = r;
					end
					ACT_PEEK: begin
						e.print_valid = 1'b1;
						e.print_value = entry(0);
					end
					ACT_POP: begin
						e.print_valid = 1'b1;
						e.print_value = entry(0);
						sp--;
					end
					ACT_SWAP: begin
						a = entry(0);
						stack_mem[sp - 1] = entry(1);
						stack_mem[sp - 2] = a;
					end
					ACT_DUP: begin
						a = entry(0);
						stack_mem[sp] = a;
						sp++;
					end
					ACT_DROP: sp--;
					ACT_NIP: begin
						a = entry(0);
						sp--;
						stack_mem[sp - 1] = a;
					end
					ACT_OVER: begin
						b = entry(1);
						stack_mem[sp] = b;
						sp++;
					end
					ACT_TOR: begin
						ret_word = entry(0);
						sp--;
					end
					ACT_RFROM: begin
						stack_mem[sp] = ret_word;
						sp++;
					end
					default: ;
				endcase
			end
			e.depth = DEPTH_W'(sp);
			awaited.push_back(e);
		endfunction

		function void check_response(rsp_t r);
			rsp_t e;
			checked++;
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("rsp %0d: none pending, got %0b/%0d/%0d/%0d",
						checked, r.print_valid, r.print_value, r.status, r.depth);
				return;
			end
			e = awaited.pop_front();
			if (r.print_valid !== e.print_valid || r.print_value !== e.print_value ||
			    r.status !== e.status || r.depth !== e.depth) begin
				faults++;
				if (faults <= 10)
					$display("rsp %0d: exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
						checked, e.print_valid, e.print_value, e.status, e.depth,
						r.print_valid, r.print_value, r.status, r.depth);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	bit calm = 1'b0;
	word_scoreboard sb = new();

	stack_machine_word_executor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic cmd_t mk(action_t a, logic [WORD_W-1:0] v);
		cmd_t c;
		c.action = a;
		c.literal = v;
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] pick_literal();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return WORD_W'($urandom_range(0, 6)) - 32'd3;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_word(int unsigned depth);
		int unsigned r, push_pct;
		cmd_t c;
		push_pct = (depth < 4) ? 50 : ((depth > 20) ? 15 : 30);
		r = $urandom_range(0, 99);
		if (r < push_pct)
			c.action = ACT_PUSH;
		else if (r < push_pct + 25)
			c.action = ACT_W'($urandom_range(ACT_ADD, ACT_MOD));
		else if (r < 96)
			c.action = ACT_W'($urandom_range(ACT_PEEK, ACT_RFROM));
		else
			c.action = ACT_W'($urandom_range(ACT_PUSH, ACT_UNKNOWN));
		c.literal = pick_literal();
		return c;
	endfunction

	task automatic hold_off(input int unsigned n);
		@(negedge clk);
		cmd_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_word(input cmd_t c);
		if (!calm && $urandom_range(0, 5) == 0)
			hold_off($urandom_range(1, 8));
		@(negedge clk);
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_word(c);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_word(mk(ACT_ADD, $urandom));
		send_word(mk(ACT_POP, $urandom));
		send_word(mk(ACT_UNKNOWN, $urandom));
		send_word(mk(ACT_RFROM, $urandom));
		send_word(mk(ACT_PUSH, 32'h7fff_ffff));
		send_word(mk(ACT_PUSH, 32'd1));
		send_word(mk(ACT_ADD, 32'd0));
		send_word(mk(ACT_DUP, 32'd0));
		send_word(mk(ACT_PUSH, 32'hffff_ffff));
		send_word(mk(ACT_DIV, 32'd0));
		send_word(mk(ACT_PUSH, 32'hffff_ffff));
		send_word(mk(ACT_MOD, 32'd0));
		send_word(mk(ACT_DIV, 32'd0));
		send_word(mk(ACT_MOD, 32'd0));
		send_word(mk(ACT_DROP, 32'd0));
		send_word(mk(ACT_PUSH, -32'sd7));
		send_word(mk(ACT_PUSH, 32'd2));
		send_word(mk(ACT_MOD, 32'd0));
		send_word(mk(ACT_SUB, 32'd0));
		send_word(mk(ACT_MUL, 32'd0));
		send_word(mk(ACT_PUSH, 32'd5));
		send_word(mk(ACT_OVER, 32'd0));
		send_word(mk(ACT_SWAP, 32'd0));
		send_word(mk(ACT_NIP, 32'd0));
		send_word(mk(ACT_PEEK, 32'd0));
		send_word(mk(ACT_TOR, 32'd0));
		send_word(mk(ACT_RFROM, 32'd0));
		send_word(mk(ACT_POP, 32'd0));
	endtask

	// fill to the top, hit overflow, then drain back down
	task automatic fill_episode();
		action_t growers [4];
		action_t shrinkers [9];
		growers = '{ACT_PUSH, ACT_DUP, ACT_OVER, ACT_RFROM};
		shrinkers = '{ACT_DROP, ACT_POP, ACT_NIP, ACT_TOR, ACT_ADD, ACT_SUB, ACT_MUL,
			ACT_DIV, ACT_MOD};
		while (sb.sp < STACK_DEPTH)
			send_word(mk(ACT_PUSH, pick_literal()));
		foreach (growers[i])
			send_word(mk(growers[i], pick_literal()));
		repeat (6) send_word(random_word(sb.sp));
		while (sb.sp > 3)
			send_word(mk(shrinkers[$urandom_range(0, 8)], pick_literal()));
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		wait_for_drain();

		for (int i = 0; i < 750; i++) begin
			if (i == 200 || i == 450)
				fill_episode();
			if (i == 520)
				wait_for_drain();
			if (i == 620)
				calm = 1'b1;
			send_word(random_word(sb.sp));
		end

		wait_for_drain();
		repeat (60) @(posedge clk);
		if (sb.faults == 0 && sb.awaited.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/smwe_pkg.sv
design/smwe_ram.sv
design/smwe_alu.sv
design/stack_machine_word_executor_core.sv
tb/sv/stack_machine_word_executor_core_tb.sv
